@@ rtl/crc8ae_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-8 frame check package
// Shared constants, stage records and the CRC-8 byte step (polynomial 0x2F).
// ----------------------------------------------------------------------------
package crc8ae_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h2F;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_XOR_OUT = 8'hFF;

  // Number of byte steps one step unit performs.
  localparam int unsigned STEP_BYTES = 3;

  // Record held after the first stage: bytes 3 to 7 are still to be folded.
  typedef struct packed {
    logic [7:0]      acc;
    logic [7:3]      mask;
    logic [7:3][7:0] data;
    logic [7:0]      magic;
    logic            known;
  } s1_t;

  // Record held after the second stage: bytes 6 and 7 are still to be folded.
  typedef struct packed {
    logic [7:0]      acc;
    logic [7:6]      mask;
    logic [7:6][7:0] data;
    logic [7:0]      magic;
    logic            known;
  } s2_t;

  // Record held in the output register.
  typedef struct packed {
    logic [7:0] crc;
    logic       known;
  } s3_t;

  // One CRC-8 byte step, MSB first.
  function automatic logic [7:0] crc_step(input logic [7:0] value);
    logic [7:0] r;
    r = value;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/crc8ae_steps.sv @@
// ----------------------------------------------------------------------------
// CRC-8 step unit
// Folds up to three bytes into a running CRC; a byte whose enable is low is
// skipped. Byte 0 is folded first.
// ----------------------------------------------------------------------------
module crc8ae_steps (
  input  logic [7:0]                                    acc_i,
  input  logic [crc8ae_pkg::STEP_BYTES-1:0][7:0]        bytes_i,
  input  logic [crc8ae_pkg::STEP_BYTES-1:0]             en_i,
  output logic [7:0]                                    acc_o
);

  // Chain of byte steps, each one optionally bypassed.
  always_comb begin
    logic [7:0] acc;
    acc = acc_i;
    for (int b = 0; b < crc8ae_pkg::STEP_BYTES; b++) begin
      if (en_i[b]) begin
        acc = crc8ae_pkg::crc_step(acc ^ bytes_i[b]);
      end
    end
    acc_o = acc;
  end

endmodule

@@ rtl/crc8ae_magic.sv @@
// ----------------------------------------------------------------------------
// Magic byte lookup
// Matches the identifier against the known list and picks the magic byte
// for the sequence counter. Unknown identifiers give zero and known low.
// ----------------------------------------------------------------------------
module crc8ae_magic (
  input  logic [28:0] can_id_i,
  input  logic [3:0]  counter_i,
  output logic [7:0]  magic_o,
  output logic        known_o
);

  localparam int unsigned IdCount = 18;

  localparam logic [10:0] MAGIC_IDS [IdCount] = '{
    11'h086, 11'h09F, 11'h0AD, 11'h0FD, 11'h106, 11'h117, 11'h120, 11'h121,
    11'h122, 11'h126, 11'h12B, 11'h12E, 11'h187, 11'h30C, 11'h30F, 11'h324,
    11'h3C0, 11'h65D
  };

  localparam logic [7:0] MAGIC_BYTES [IdCount][16] = '{
    '{8'h86,8'h86,8'h86,8'h86,8'h86,8'h86,8'h86,8'h86,
      8'h86,8'h86,8'h86,8'h86,8'h86,8'h86,8'h86,8'h86},
    '{8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,
      8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,8'hF5,8'hF5},
    '{8'h3F,8'h69,8'h39,8'hDC,8'h94,8'hF9,8'h14,8'h64,
      8'hD8,8'h6A,8'h34,8'hCE,8'hA2,8'h55,8'hB5,8'h2C},
    '{8'hB4,8'hEF,8'hF8,8'h49,8'h1E,8'hE5,8'hC2,8'hC0,
      8'h97,8'h19,8'h3C,8'hC9,8'hF1,8'h98,8'hD6,8'h61},
    '{8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,
      8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07},
    '{8'h16,8'h16,8'h16,8'h16,8'h16,8'h16,8'h16,8'h16,
      8'h16,8'h16,8'h16,8'h16,8'h16,8'h16,8'h16,8'h16},
    '{8'hC4,8'hE2,8'h4F,8'hE4,8'hF8,8'h2F,8'h56,8'h81,
      8'h9F,8'hE5,8'h83,8'h44,8'h05,8'h3F,8'h97,8'hDF},
    '{8'hE9,8'h65,8'hAE,8'h6B,8'h7B,8'h35,8'hE5,8'h5F,
      8'h4E,8'hC7,8'h86,8'hA2,8'hBB,8'hDD,8'hEB,8'hB4},
    '{8'h37,8'h7D,8'hF3,8'hA9,8'h18,8'h46,8'h6D,8'h4D,
      8'h3D,8'h71,8'h92,8'h9C,8'hE5,8'h32,8'h10,8'hB9},
    '{8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,
      8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,8'hDA,8'hDA},
    '{8'h6A,8'h38,8'hB4,8'h27,8'h22,8'hEF,8'hE1,8'hBB,
      8'hF8,8'h80,8'h84,8'h49,8'hC7,8'h9E,8'h1E,8'h2B},
    '{8'hF8,8'hE5,8'h97,8'hC9,8'hD6,8'h07,8'h47,8'h21,
      8'h66,8'hDD,8'hCF,8'h6F,8'hA1,8'h94,8'h74,8'h63},
    '{8'h7F,8'hED,8'h17,8'hC2,8'h7C,8'hEB,8'h44,8'h21,
      8'h01,8'hFA,8'hDB,8'h15,8'h4A,8'h6B,8'h23,8'h05},
    '{8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,
      8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,8'h0F,8'h0F},
    '{8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,
      8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C},
    '{8'h27,8'h27,8'h27,8'h27,8'h27,8'h27,8'h27,8'h27,
      8'h27,8'h27,8'h27,8'h27,8'h27,8'h27,8'h27,8'h27},
    '{8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,
      8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3},
    '{8'hAC,8'hB3,8'hAB,8'hEB,8'h7A,8'hE1,8'h3B,8'hF7,
      8'h73,8'hBA,8'h7C,8'h9E,8'h06,8'h5F,8'h02,8'hD9}
  };

  // Each identifier compare is independent; the list holds no duplicates,
  // so an OR of the selected rows picks the single matching one.
  always_comb begin
    logic [7:0] magic;
    logic       known;
    magic = '0;
    known = 1'b0;
    for (int i = 0; i < IdCount; i++) begin
      if (can_id_i == {18'd0, MAGIC_IDS[i]}) begin
        magic = magic | MAGIC_BYTES[i][counter_i];
        known = 1'b1;
      end
    end
    magic_o = magic;
    known_o = known;
  end

endmodule

@@ rtl/can_frame_crc8_autosar_e2e_core.sv @@
// ----------------------------------------------------------------------------
// CAN frame CRC-8 check value core
// An accepted item passes through the stage one, two and three registers and
// is driven out from the stage three register. Throughput is one item per cycle
// while the output is not stalled; each stage folds at most three CRC bytes.
// Stages stall independently, so bubbles are squeezed out under back-pressure.
// Reset clears the stage valid bits only; the pipeline starts empty.
// ----------------------------------------------------------------------------
module can_frame_crc8_autosar_e2e_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [28:0] can_id_i,
  input  logic [63:0] payload_i,
  input  logic [3:0]  length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  crc_o,
  output logic        id_known_o
);

  logic v1_q, v2_q, v3_q;
  logic ld1, ld2, ld3;
  crc8ae_pkg::s1_t s1_d, s1_q;
  crc8ae_pkg::s2_t s2_d, s2_q;
  crc8ae_pkg::s3_t s3_d, s3_q;

  // A stage loads when it is empty or its item moves on in the same cycle.
  assign ld3 = !v3_q || !out_stall_i;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign in_stall_o = !ld1;

  // Stage one: identifier lookup and payload bytes 1 and 2.
  logic [7:0] magic;
  logic       known;
  logic [7:0] acc1;
  logic [7:1] mask;

  crc8ae_magic u_magic (
    .can_id_i  (can_id_i),
    .counter_i (payload_i[11:8]),
    .magic_o   (magic),
    .known_o   (known)
  );

  // Byte i takes part when it lies inside the frame; longer lengths saturate.
  always_comb begin
    for (int i = 1; i < 8; i++) begin
      mask[i] = ({28'd0, length_i} > i);
    end
  end

  crc8ae_steps u_steps1 (
    .acc_i   (crc8ae_pkg::CRC_INIT),
    .bytes_i ({8'h00, payload_i[23:16], payload_i[15:8]}),
    .en_i    ({1'b0, mask[2], mask[1]}),
    .acc_o   (acc1)
  );

  always_comb begin
    s1_d.acc   = acc1;
    s1_d.mask  = mask[7:3];
    s1_d.data  = payload_i[63:24];
    s1_d.magic = magic;
    s1_d.known = known;
  end

  // Stage two: payload bytes 3 to 5.
  logic [7:0] acc2;

  crc8ae_steps u_steps2 (
    .acc_i   (s1_q.acc),
    .bytes_i ({s1_q.data[5], s1_q.data[4], s1_q.data[3]}),
    .en_i    (s1_q.mask[5:3]),
    .acc_o   (acc2)
  );

  always_comb begin
    s2_d.acc   = acc2;
    s2_d.mask  = s1_q.mask[7:6];
    s2_d.data  = {s1_q.data[7], s1_q.data[6]};
    s2_d.magic = s1_q.magic;
    s2_d.known = s1_q.known;
  end

  // Stage three: payload bytes 6 and 7, then the magic byte and final XOR.
  logic [7:0] acc3;

  crc8ae_steps u_steps3 (
    .acc_i   (s2_q.acc),
    .bytes_i ({s2_q.magic, s2_q.data[7], s2_q.data[6]}),
    .en_i    ({1'b1, s2_q.mask[7], s2_q.mask[6]}),
    .acc_o   (acc3)
  );

  always_comb begin
    s3_d.crc   = acc3 ^ crc8ae_pkg::CRC_XOR_OUT;
    s3_d.known = s2_q.known;
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage payload registers, loaded only with a valid item.
  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (ld2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (ld3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign crc_o       = s3_q.crc;
  assign id_known_o  = s3_q.known;

endmodule

@@ tb/tb_can_frame_crc8_autosar_e2e_core.sv @@
// ----------------------------------------------------------------------------
// CAN frame CRC-8 check value core testbench
// Drives CAN frames through the valid/stall input channel with random idling,
// predicts each check byte and identifier flag in the testbench, and compares
// them in order with the results taken from the output channel.
// ----------------------------------------------------------------------------
module tb_can_frame_crc8_autosar_e2e_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  FRAME_POLY     = 8'h2F;
  localparam logic [7:0]  FRAME_SEED     = 8'hFF;
  localparam logic [7:0]  FRAME_FINAL    = 8'hFF;
  localparam int unsigned TABLE_IDS      = 18;
  localparam int unsigned IDLE_PERCENT   = 37;
  localparam int unsigned RANDOM_FRAMES  = 1740;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  typedef struct packed {
    logic [7:0] crc;
    logic       known;
  } frame_check_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [28:0] can_id_i    = '0;
  logic [63:0] payload_i   = '0;
  logic [3:0]  length_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  crc_o;
  logic        id_known_o;

  frame_check_t pending_checks[$];
  int unsigned  fault_count  = 0;
  int unsigned  cycle_count  = 0;
  logic         steady_flow  = 1'b0;

  can_frame_crc8_autosar_e2e_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .can_id_i    (can_id_i),
    .payload_i   (payload_i),
    .length_i    (length_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_o       (crc_o),
    .id_known_o  (id_known_o)
  );

  // Free-running clock with a 4 ns period.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Identifiers that carry a magic byte table, in table order.
  function automatic logic [28:0] table_id(input int unsigned k);
    case (k)
      0:       return 29'h086;
      1:       return 29'h09F;
      2:       return 29'h0AD;
      3:       return 29'h0FD;
      4:       return 29'h106;
      5:       return 29'h117;
      6:       return 29'h120;
      7:       return 29'h121;
      8:       return 29'h122;
      9:       return 29'h126;
      10:      return 29'h12B;
      11:      return 29'h12E;
      12:      return 29'h187;
      13:      return 29'h30C;
      14:      return 29'h30F;
      15:      return 29'h324;
      16:      return 29'h3C0;
      default: return 29'h65D;
    endcase
  endfunction

  // Sixteen magic bytes per identifier; the byte for counter 0 is the top byte.
  function automatic logic [127:0] table_row(input int unsigned k);
    case (k)
      0:       return {16{8'h86}};
      1:       return {16{8'hF5}};
      2:       return 128'h3F6939DC94F91464D86A34CEA255B52C;
      3:       return 128'hB4EFF8491EE5C2C097193CC9F198D661;
      4:       return {16{8'h07}};
      5:       return {16{8'h16}};
      6:       return 128'hC4E24FE4F82F56819FE58344053F97DF;
      7:       return 128'hE965AE6B7B35E55F4EC786A2BBDDEBB4;
      8:       return 128'h377DF3A918466D4D3D71929CE53210B9;
      9:       return {16{8'hDA}};
      10:      return 128'h6A38B42722EFE1BBF8808449C79E1E2B;
      11:      return 128'hF8E597C9D607472166DDCF6FA1947463;
      12:      return 128'h7FED17C27CEB442101FADB154A6B2305;
      13:      return {16{8'h0F}};
      14:      return {16{8'h0C}};
      15:      return {16{8'h27}};
      16:      return {16{8'hC3}};
      default: return 128'hACB3ABEB7AE13BF773BA7C9E065F02D9;
    endcase
  endfunction

  // Shifts one byte through the CRC-8 divider, most significant bit first.
  function automatic logic [7:0] crc8_divide(input logic [7:0] value);
    logic [7:0] rem;
    rem = value;
    repeat (8) begin
      rem = {rem[6:0], 1'b0} ^ (rem[7] ? FRAME_POLY : 8'h00);
    end
    return rem;
  endfunction

  // Works out the check byte and identifier flag for one frame.
  function automatic frame_check_t frame_check(input logic [28:0] id,
                                               input logic [63:0] data,
                                               input logic [3:0]  len);
    frame_check_t res;
    logic [7:0]   acc;
    logic [7:0]   magic;
    logic [3:0]   counter;
    logic [127:0] row;
    int unsigned  span;
    acc       = FRAME_SEED;
    magic     = 8'h00;
    res.known = 1'b0;
    counter   = data[11:8];
    span      = (len > 4'd8) ? 8 : len;
    // Data bytes after the check byte slot, clipped at eight bytes.
    for (int unsigned i = 1; i < span; i++) begin
      acc = crc8_divide(acc ^ data[8*i +: 8]);
    end
    // The counter nibble is taken even when byte 1 lies outside the frame.
    for (int unsigned k = 0; k < TABLE_IDS; k++) begin
      if (!res.known && id == table_id(k)) begin
        row       = table_row(k);
        magic     = row[8*(15 - counter) +: 8];
        res.known = 1'b1;
      end
    end
    res.crc = crc8_divide(acc ^ magic) ^ FRAME_FINAL;
    return res;
  endfunction

  // Cycle counter with a hard limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output back-pressure, switched off during the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Compares every result that is taken at the next edge with the oldest
  // prediction; sampling at the falling edge keeps clear of the driving edge.
  always @(negedge clk_i) begin
    frame_check_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_checks.size() == 0) begin
        if (fault_count < REPORT_LIMIT) begin
          $display("unexpected result: crc %h known %b", crc_o, id_known_o);
        end
        fault_count++;
      end else begin
        want = pending_checks.pop_front();
        if (crc_o !== want.crc || id_known_o !== want.known) begin
          if (fault_count < REPORT_LIMIT) begin
            $display("mismatch: crc expected %h got %h, known expected %b got %b",
                     want.crc, crc_o, want.known, id_known_o);
          end
          fault_count++;
        end
      end
    end
  end

  // Offers one frame, idling first at random, and records its prediction once
  // it is taken. Valid stays high on return so back-to-back items need no gap.
  task automatic send_frame(input logic [28:0] id, input logic [63:0] data,
                            input logic [3:0] len);
    logic stalled;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    can_id_i   <= id;
    payload_i  <= data;
    length_i   <= len;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_checks.push_back(frame_check(id, data, len));
  endtask

  // Holds the input channel idle until every predicted result has come.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_checks.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] random_payload();
    return {$urandom(), $urandom()};
  endfunction

  // Zero and all-ones fields, known and unknown identifiers.
  task automatic test_field_extremes();
    send_frame(29'h0, 64'h0, 4'd1);
    send_frame(29'h1FFF_FFFF, {64{1'b1}}, 4'd8);
    send_frame(table_id(0), {64{1'b1}}, 4'd8);
    send_frame(table_id(17), 64'h0, 4'd8);
    send_frame(29'h7FF, random_payload(), 4'd8);
  endtask

  // Lengths of zero and one fold no data; lengths above eight clip to eight.
  task automatic test_length_edges();
    logic [63:0] data;
    data = 64'h0123_4567_89AB_CD05;
    send_frame(table_id(2), data, 4'd0);
    send_frame(table_id(2), data, 4'd1);
    send_frame(table_id(2), data, 4'd9);
    send_frame(table_id(2), data, 4'd15);
  endtask

  // Every table identifier once, walking through the counter values.
  task automatic test_table_ids();
    logic [63:0] data;
    for (int unsigned k = 0; k < TABLE_IDS; k++) begin
      data       = random_payload();
      data[11:8] = k[3:0];
      send_frame(table_id(k), data, 4'($urandom_range(2, 8)));
    end
  endtask

  // Picks an identifier: mostly table entries, plus near misses and random ids.
  function automatic logic [28:0] random_id();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return table_id($urandom_range(0, TABLE_IDS - 1));
    end else if (pick < 65) begin
      return table_id($urandom_range(0, TABLE_IDS - 1)) ^ (29'h1 << $urandom_range(0, 28));
    end else if (pick < 80) begin
      return 29'($urandom_range(0, 11'h7FF));
    end
    return 29'($urandom());
  endfunction

  // Random frames with a stretch of uninterrupted flow starting a quarter of the way in.
  task automatic test_random_frames(input int unsigned count);
    logic [3:0] len;
    for (int unsigned n = 0; n < count; n++) begin
      steady_flow <= (n >= count / 4) && (n < count / 4 + 300);
      if ($urandom_range(0, 99) < 85) begin
        len = 4'($urandom_range(1, 8));
      end else begin
        len = 4'($urandom_range(0, 15));
      end
      send_frame(random_id(), random_payload(), len);
    end
    steady_flow <= 1'b0;
  endtask

  // The sender stops until the pipeline has emptied, then carries on.
  task automatic test_drain_pause();
    for (int unsigned n = 0; n < 40; n++) begin
      if (n == 20) begin
        wait_for_drain();
      end
      send_frame(random_id(), random_payload(), 4'($urandom_range(1, 8)));
    end
  endtask

  // Sequence of tests and the final verdict.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_length_edges();
    test_table_ids();
    test_drain_pause();
    test_random_frames(RANDOM_FRAMES);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && pending_checks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
